// ----- design/iida_pkg.sv -----
// Package for the indexed insert/delete array: item types, codes and the cell command.
package iida_pkg;

  localparam int COUNT_W = 5;   // entry count and capacity width
  localparam int INDEX_W = 4;   // index field width
  localparam int DATA_W  = 32;  // entry width
  localparam int ACT_W   = 3;   // action code width
  localparam int STAT_W  = 2;   // status code width

  // action codes
  localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_OVERWRITE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADINDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_full;
    logic                      is_empty;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                      ins;    // open a slot at pos, shift later entries up
    logic                      del;    // close the slot at pos, shift later entries down
    logic                      wr;     // overwrite the entry at pos
    logic [COUNT_W-1:0]        pos;
    logic [DATA_W-1:0]         value;
  } cell_cmd_t;

endpackage

// ----- design/iida_cell.sv -----
// One storage cell of the list chain: holds a single entry and trades it with its neighbors.
module iida_cell import iida_pkg::*; #(
  parameter int POS = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_data,   // entry of the cell below
  input  logic [DATA_W-1:0] right_data,  // entry of the cell above
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (POS > int'(cmd.pos)) begin
        data_nxt = left_data;
      end else if (POS == int'(cmd.pos)) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.del) begin
      if (POS >= int'(cmd.pos)) begin
        data_nxt = right_data;
      end
    end else if (cmd.wr) begin
      if (POS == int'(cmd.pos)) begin
        data_nxt = cmd.value;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- design/indexed_insert_delete_array_core.sv -----
// Top level of the indexed insert/delete array: control, cell chain and result register.
// Bounded ordered list of signed 32-bit words held in a chain of DEPTH cells. Each item
// carries an action (append, insert at index, delete at index, read at index, overwrite at
// index) and yields exactly one result item with status, read value, entry count and
// full/empty flags. Every action is applied at once: all cells shift toward or away
// from the index in parallel on the same clock edge, so the sustained rate is one item per
// cycle unless the input stalls; the result is registered. The result register lets a
// new item be taken while the last result is still waiting; input stalls only when that
// register is full and the result side stalls. The capacity register (cfg_data) limits
// how many entries are usable: 0 acts as 1 and values above DEPTH act as DEPTH. Lowering
// it below the current count drops nothing; the list just reports full. Entries past the
// count hold stale data and are never reported. No clearing pass is needed after reset.
module indexed_insert_delete_array_core import iida_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  // capacity register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] cap_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [COUNT_W-1:0] cap_eff;
  logic               full_now;
  logic [COUNT_W-1:0] idx_ext;
  logic               in_range;
  logic               accept;
  cell_cmd_t          cmd;
  logic [DATA_W-1:0]  rd_mux;
  out_item_t          result;

  logic [DATA_W-1:0]  cell_data [DEPTH];

  // config port always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= COUNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = COUNT_W'(1);
    end else if (int'(cap_r) > DEPTH) begin
      cap_eff = COUNT_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign full_now = (count_r >= cap_eff);
  assign idx_ext  = {1'b0, in_item.index};
  assign in_range = (idx_ext < count_r);

  // input stalls only when the result register is held
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // read port: select the addressed cell
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(in_item.index) == i) begin
        rd_mux = cell_data[i];
      end
    end
  end

  // action decode
  always_comb begin
    cmd           = '0;
    cmd.value     = in_item.value;
    cmd.pos       = idx_ext;
    count_nxt     = count_r;
    result        = '0;
    result.status = ST_OK;
    unique case (in_item.action)
      ACT_APPEND: begin
        if (full_now) begin
          result.status = ST_OVERFLOW;
        end else begin
          // append is an insert at the tail
          cmd.ins   = accept;
          cmd.pos   = count_r;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      ACT_INSERT: begin
        if (idx_ext > count_r) begin
          result.status = ST_BADINDEX;
        end else if (full_now) begin
          result.status = ST_OVERFLOW;
        end else begin
          cmd.ins   = accept;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (!in_range) begin
          result.status = ST_BADINDEX;
        end else begin
          cmd.del   = accept;
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      ACT_READ: begin
        if (!in_range) begin
          result.status = ST_BADINDEX;
        end else begin
          result.read_value = rd_mux;
        end
      end
      ACT_OVERWRITE: begin
        if (!in_range) begin
          result.status = ST_BADINDEX;
        end else begin
          cmd.wr = accept;
        end
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
    result.entry_count = count_nxt;
    result.is_full     = (count_nxt >= cap_eff);
    result.is_empty    = (count_nxt == '0);
  end

  // cell chain; the ends see zero from the missing neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (g == 0) begin : g_lo
      assign left_d = '0;
    end else begin : g_lo
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign right_d = '0;
    end else begin : g_hi
      assign right_d = cell_data[g+1];
    end
    iida_cell #(
      .POS (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[g])
    );
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // count never runs past the chain
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("entry count exceeds depth");

  // a delivered result is never both full and empty
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.is_full && out_item_r.is_empty))
    else $error("result flagged full and empty");

  // an accepted append on a list with room grows the count by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.action == ACT_APPEND && !full_now)
      |=> count_r == $past(count_r) + COUNT_W'(1))
    else $error("append did not grow the count");

  // the reported count matches the stored count after every accepted item
  a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_item_r.entry_count == count_r)
    else $error("reported count differs from stored count");

endmodule
